FILE: hw/rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and defaults for the strongly connected components block.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int DEF_MAX_VERTICES = 32;
    localparam int DEF_MAX_DEGREE   = 8;
    localparam logic [5:0] VERTEX_COUNT_RESET = 6'd32;

    typedef struct packed {
        logic [4:0] edge_from;
        logic [4:0] edge_to;
        logic       last_edge;
    } in_item_t;

    typedef struct packed {
        logic [4:0] vertex;
        logic       component_end;
        logic       run_end;
        logic       edge_dropped;
    } out_item_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_ROOT,
        S_TOP,
        S_NBR,
        S_RET,
        S_POP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_ready;
        logic do_load;
        logic root_next;
        logic enter_root;
        logic enter_w;
        logic fetch;
        logic lower;
        logic ret;
        logic pop;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic csp_zero;
        logic root_end;
        logic root_visited;
        logic edge_avail;
        logic w_out;
        logic w_visited;
        logic w_lower;
        logic is_head;
        logic pop_last;
        logic out_free;
    } status_t;

endpackage

FILE: hw/rtl/strongly_connected_components.sv
// ----------------------------------------------------------------------------
// strongly_connected_components
// Tarjan component search over a directed graph loaded one edge per item.
//
//   channel  direction  item        handshake
//   in       input      in_item_t   in_valid / in_stall
//   out      output     out_item_t  out_valid / out_stall
//   cfg      input      vertex cnt  cfg_wr_en / cfg_wr_data
//
// Edges load one per cycle. The last edge starts the search, paced by
// the single-step sequencer and the neighbor store read port; output
// stalls hold it in the pop and done states.
// Input stalls for the whole search. Reset clears the degree counts,
// flags and stacks at once; no clearing pass.
// ----------------------------------------------------------------------------
module strongly_connected_components #(
    parameter int MAX_VERTICES = scc_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = scc_pkg::DEF_MAX_DEGREE
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [5:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  scc_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output scc_pkg::out_item_t out_item
);
    import scc_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign in_stall = !cmd.load_ready;

    scc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_item.last_edge),
        .status   (status),
        .cmd      (cmd)
    );

    scc_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (in_item),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

endmodule

FILE: hw/rtl/scc_ctrl.sv
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer for edge loading and the depth-first component search.
// ----------------------------------------------------------------------------
module scc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    input  scc_pkg::status_t  status,
    output scc_pkg::cmd_t     cmd
);
    import scc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (status.root_end)
                begin
                    state_next = S_DONE;
                end
                else if (!status.root_visited)
                begin
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                if (status.csp_zero)
                begin
                    state_next = S_ROOT;
                end
                else if (status.edge_avail)
                begin
                    state_next = S_NBR;
                end
                else
                begin
                    state_next = S_RET;
                end
            end
            S_NBR:
            begin
                state_next = S_TOP;
            end
            S_RET:
            begin
                state_next = status.is_head ? S_POP : S_TOP;
            end
            S_POP:
            begin
                if (status.out_free && status.pop_last)
                begin
                    state_next = S_TOP;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_LOAD:
            begin
                cmd.load_ready = 1'b1;
                cmd.do_load    = in_valid;
            end
            S_ROOT:
            begin
                if (!status.root_end)
                begin
                    cmd.root_next  = status.root_visited;
                    cmd.enter_root = !status.root_visited;
                end
            end
            S_TOP:
            begin
                cmd.root_next = status.csp_zero;
                cmd.fetch     = !status.csp_zero && status.edge_avail;
            end
            S_NBR:
            begin
                if (!status.w_out)
                begin
                    cmd.enter_w = !status.w_visited;
                    cmd.lower   = status.w_visited && status.w_lower;
                end
            end
            S_RET:
            begin
                cmd.ret = 1'b1;
            end
            S_POP:
            begin
                cmd.pop = status.out_free;
            end
            S_DONE:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/scc_dp.sv
// ----------------------------------------------------------------------------
// scc_dp
// Graph store, search state, stacks and result staging.
// ----------------------------------------------------------------------------
module scc_dp #(
    parameter int MAX_VERTICES = scc_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = scc_pkg::DEF_MAX_DEGREE
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [5:0]         cfg_wr_data,
    input  scc_pkg::in_item_t  in_item,
    input  scc_pkg::cmd_t      cmd,
    output scc_pkg::status_t   status,
    output logic               out_valid,
    input  logic               out_stall,
    output scc_pkg::out_item_t out_item
);
    import scc_pkg::*;

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int PW = $clog2(MAX_VERTICES + 1);
    localparam int CW = $clog2(MAX_DEGREE + 1);
    localparam int IW = $clog2(MAX_VERTICES + 2);
    localparam int AW = (MAX_VERTICES * MAX_DEGREE > 1) ?
                        $clog2(MAX_VERTICES * MAX_DEGREE) : 1;
    localparam int NDEPTH = MAX_VERTICES * MAX_DEGREE;

    logic [5:0]    vcount_reg;
    logic [4:0]    nbr_mem [NDEPTH];
    logic [4:0]    nbr_q_reg;
    logic [CW-1:0] deg_reg [MAX_VERTICES];
    logic [IW-1:0] disc_reg [MAX_VERTICES];
    logic [IW-1:0] low_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] onstk_reg;
    logic [VW-1:0] comp_reg [MAX_VERTICES];
    logic [VW-1:0] callv_reg [MAX_VERTICES];
    logic [CW-1:0] calle_reg [MAX_VERTICES];
    logic [IW-1:0] next_idx_reg;
    logic          ovf_reg;
    logic [PW-1:0] csp_reg;
    logic [PW-1:0] ssp_reg;
    logic [PW-1:0] root_reg;
    logic [VW-1:0] v_reg;
    logic          pend_valid_reg;
    logic [4:0]    pend_vertex_reg;
    logic          pend_cend_reg;
    logic          out_valid_reg;
    out_item_t     out_reg;

    logic [31:0]   n32;
    logic [VW-1:0] from_v;
    logic          edge_ok;
    logic [VW-1:0] v_top;
    logic [CW-1:0] e_top;
    logic [VW-1:0] w_v;
    logic [VW-1:0] root_v;
    logic [VW-1:0] ent_v;
    logic [VW-1:0] top_idx;
    logic [VW-1:0] par_idx;
    logic [VW-1:0] u_v;
    logic [VW-1:0] x_v;
    logic [VW-1:0] stk_idx;
    logic          out_free;

    assign n32 = (32'(vcount_reg) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES)
                                                       : 32'(vcount_reg);
    assign from_v  = VW'(in_item.edge_from);
    assign edge_ok = (32'(in_item.edge_from) < n32) && (32'(in_item.edge_to) < n32)
                     && (32'(deg_reg[from_v]) < 32'(MAX_DEGREE));
    assign top_idx = VW'(csp_reg - PW'(1));
    assign par_idx = VW'(csp_reg - PW'(2));
    assign v_top   = callv_reg[top_idx];
    assign e_top   = calle_reg[top_idx];
    assign u_v     = callv_reg[par_idx];
    assign w_v     = VW'(nbr_q_reg);
    assign root_v  = VW'(root_reg);
    assign ent_v   = cmd.enter_root ? root_v : w_v;
    assign stk_idx = VW'(ssp_reg - PW'(1));
    assign x_v     = comp_reg[stk_idx];
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        status.csp_zero     = (csp_reg == '0);
        status.root_end     = (32'(root_reg) >= n32);
        status.root_visited = visited_reg[root_v];
        status.edge_avail   = (e_top < deg_reg[v_top])
                              && (32'(e_top) < 32'(MAX_DEGREE));
        status.w_out        = (32'(nbr_q_reg) >= n32);
        status.w_visited    = visited_reg[w_v];
        status.w_lower      = onstk_reg[w_v] && (disc_reg[w_v] < low_reg[v_top]);
        status.is_head      = (low_reg[v_top] == disc_reg[v_top]);
        status.pop_last     = (x_v == v_reg) || (ssp_reg == PW'(1));
        status.out_free     = out_free;
    end

    // neighbor store: one write port for loading, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.do_load && edge_ok)
        begin
            nbr_mem[AW'(from_v) * AW'(MAX_DEGREE) + AW'(deg_reg[from_v])] <= in_item.edge_to;
        end
        if (cmd.fetch)
        begin
            nbr_q_reg <= nbr_mem[AW'(v_top) * AW'(MAX_DEGREE) + AW'(e_top)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.enter_root || cmd.enter_w)
        begin
            disc_reg[ent_v] <= next_idx_reg;
            low_reg[ent_v]  <= next_idx_reg;
            comp_reg[VW'(ssp_reg)]  <= ent_v;
            callv_reg[VW'(csp_reg)] <= ent_v;
            calle_reg[VW'(csp_reg)] <= '0;
        end
        if (cmd.fetch)
        begin
            calle_reg[top_idx] <= e_top + CW'(1);
        end
        if (cmd.lower)
        begin
            low_reg[v_top] <= disc_reg[w_v];
        end
        if (cmd.ret)
        begin
            v_reg <= v_top;
            if (csp_reg >= PW'(2) && low_reg[v_top] < low_reg[u_v])
            begin
                low_reg[u_v] <= low_reg[v_top];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg     <= VERTEX_COUNT_RESET;
            visited_reg    <= '0;
            onstk_reg      <= '0;
            next_idx_reg   <= IW'(1);
            ovf_reg        <= 1'b0;
            csp_reg        <= '0;
            ssp_reg        <= '0;
            root_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                deg_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vcount_reg <= cfg_wr_data;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.do_load)
            begin
                if (edge_ok)
                begin
                    deg_reg[from_v] <= deg_reg[from_v] + CW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.root_next)
            begin
                root_reg <= root_reg + PW'(1);
            end
            if (cmd.enter_root || cmd.enter_w)
            begin
                next_idx_reg       <= next_idx_reg + IW'(1);
                visited_reg[ent_v] <= 1'b1;
                onstk_reg[ent_v]   <= 1'b1;
                ssp_reg            <= ssp_reg + PW'(1);
                csp_reg            <= csp_reg + PW'(1);
            end
            if (cmd.ret)
            begin
                csp_reg <= csp_reg - PW'(1);
            end
            if (cmd.pop)
            begin
                ssp_reg          <= ssp_reg - PW'(1);
                onstk_reg[x_v]   <= 1'b0;
                pend_valid_reg   <= 1'b1;
                pend_vertex_reg  <= 5'(x_v);
                pend_cend_reg    <= (x_v == v_reg);
                if (pend_valid_reg)
                begin
                    out_valid_reg         <= 1'b1;
                    out_reg.vertex        <= pend_vertex_reg;
                    out_reg.component_end <= pend_cend_reg;
                    out_reg.run_end       <= 1'b0;
                    out_reg.edge_dropped  <= ovf_reg;
                end
            end
            if (cmd.finish)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_reg         <= 1'b1;
                    out_reg.vertex        <= pend_vertex_reg;
                    out_reg.component_end <= pend_cend_reg;
                    out_reg.run_end       <= 1'b1;
                    out_reg.edge_dropped  <= ovf_reg;
                end
                pend_valid_reg <= 1'b0;
                visited_reg    <= '0;
                onstk_reg      <= '0;
                next_idx_reg   <= IW'(1);
                ovf_reg        <= 1'b0;
                csp_reg        <= '0;
                ssp_reg        <= '0;
                root_reg       <= '0;
                for (int i = 0; i < MAX_VERTICES; i++)
                begin
                    deg_reg[i] <= '0;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

FILE: hw/rtl/scc_checker.sv
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks for the component search block.
// ----------------------------------------------------------------------------
module scc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input scc_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_stall,
    input scc_pkg::out_item_t out_item
);
    import scc_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled item changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_item.last_edge |=> in_stall)
        else $error("input taken after last edge");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !in_item.last_edge |=> !in_stall)
        else $error("loading stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_item.run_end |=> !out_valid)
        else $error("item after run end");

endmodule

bind strongly_connected_components scc_checker u_scc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
